@@ hdl/gcab_pkg.sv @@
package gcab_pkg;

  // surface coordinate width
  localparam int COORD_WIDTH = 12;

  // fixed widths of the clip registers
  localparam int CLIP_LO_W = 12;
  localparam int CLIP_HI_W = 13;

  // width used for the window compares, wide enough for either side
  localparam int CMP_W = (COORD_WIDTH > CLIP_HI_W) ? COORD_WIDTH : CLIP_HI_W;

  localparam int PIXEL_W = 32;
  localparam int COV_W   = 8;
  localparam int CHAN_W  = 8;
  localparam int PROD_W  = 2 * CHAN_W;
  localparam int NUM_CH  = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_WORD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM  = 3'd5;

  localparam logic [CLIP_HI_W-1:0] CLIP_HI_RESET = 13'd4096;

  localparam logic [COV_W-1:0] COV_NONE = 8'd0;
  localparam logic [COV_W-1:0] COV_FULL = 8'd255;

  // channel slots, alpha on top as in the ARGB word
  localparam int CH_A = 3;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CLS_SKIP,
    CLS_FULL,
    CLS_BLEND
  } cls_t;

  // one queued pixel: class, source channel products and the word to pass on
  typedef struct packed {
    cls_t                           cls;
    logic [NUM_CH-1:0][PROD_W-1:0]  prod;
    logic [PIXEL_W-1:0]             word;
  } entry_t;

  typedef struct packed {
    logic full;
    logic nempty;
  } qstat_t;

endpackage

@@ hdl/gcab_front.sv @@
module gcab_front (
  input  logic [gcab_pkg::COORD_WIDTH-1:0] pixel_x,
  input  logic [gcab_pkg::COORD_WIDTH-1:0] pixel_y,
  input  logic [gcab_pkg::COV_W-1:0]       coverage,
  input  logic [gcab_pkg::PIXEL_W-1:0]     dest_pixel,
  input  logic [gcab_pkg::PIXEL_W-1:0]     source_color,
  input  logic [gcab_pkg::PIXEL_W-1:0]     full_word,
  input  logic [gcab_pkg::CLIP_LO_W-1:0]   clip_left,
  input  logic [gcab_pkg::CLIP_LO_W-1:0]   clip_top,
  input  logic [gcab_pkg::CLIP_HI_W-1:0]   clip_right,
  input  logic [gcab_pkg::CLIP_HI_W-1:0]   clip_bottom,
  output gcab_pkg::entry_t                 entry
);

  logic [gcab_pkg::CMP_W-1:0] x_ext;
  logic [gcab_pkg::CMP_W-1:0] y_ext;
  logic                       in_window;

  assign x_ext = gcab_pkg::CMP_W'(pixel_x);
  assign y_ext = gcab_pkg::CMP_W'(pixel_y);

  // an empty window fails one of these compares on its own
  assign in_window = (x_ext >= gcab_pkg::CMP_W'(clip_left))  &&
                     (x_ext <  gcab_pkg::CMP_W'(clip_right)) &&
                     (y_ext >= gcab_pkg::CMP_W'(clip_top))   &&
                     (y_ext <  gcab_pkg::CMP_W'(clip_bottom));

  always_comb begin
    for (int i = 0; i < gcab_pkg::NUM_CH; i++) begin
      entry.prod[i] = {8'd0, source_color[i*gcab_pkg::CHAN_W +: gcab_pkg::CHAN_W]} *
                      {8'd0, coverage};
    end
    entry.word = dest_pixel;
    if (!in_window || coverage == gcab_pkg::COV_NONE) begin
      entry.cls = gcab_pkg::CLS_SKIP;
    end else if (coverage == gcab_pkg::COV_FULL) begin
      entry.cls  = gcab_pkg::CLS_FULL;
      entry.word = full_word;
    end else begin
      entry.cls = gcab_pkg::CLS_BLEND;
    end
  end

endmodule

@@ hdl/gcab_queue.sv @@
module gcab_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gcab_pkg::entry_t push_entry,
  input  logic             pop,
  output gcab_pkg::entry_t head_entry,
  output gcab_pkg::qstat_t stat
);

  gcab_pkg::entry_t                 slot_r [gcab_pkg::QUEUE_DEPTH];
  logic [gcab_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [gcab_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [gcab_pkg::QCNT_W-1:0]      count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == gcab_pkg::QPTR_W'(gcab_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == gcab_pkg::QPTR_W'(gcab_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head_entry  = slot_r[rd_ptr_r];
  assign stat.full   = (count_r == gcab_pkg::QCNT_W'(gcab_pkg::QUEUE_DEPTH));
  assign stat.nempty = (count_r != '0);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= gcab_pkg::QCNT_W'(gcab_pkg::QUEUE_DEPTH))
    else $error("queue count past depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.nempty)
    else $error("pop from empty queue");
`endif

endmodule

@@ hdl/gcab_back.sv @@
module gcab_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gcab_pkg::entry_t             head_entry,
  input  gcab_pkg::qstat_t             stat,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gcab_pkg::PIXEL_W-1:0] out_pixel_out,
  output logic                         out_write_enable
);

  logic                                           out_valid_r;
  logic [gcab_pkg::PIXEL_W-1:0]                   pixel_r, pixel_nxt;
  logic                                           we_r, we_nxt;
  logic [gcab_pkg::NUM_CH-1:0][gcab_pkg::CHAN_W-1:0] src_s;
  logic [gcab_pkg::CHAN_W-1:0]                    src_a;

  // round(v / 255) via the add-and-shift trick
  function automatic logic [7:0] div255_round(input logic [15:0] v);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, v} + 17'd128;
    u = t + {8'd0, t[16:8]};
    return u[15:8];
  endfunction

  // source-over with divide by 256; the sum keeps only bits 7..0, and only bits 15..8 of the difference survive
  function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] sa);
    logic [8:0]  sum;
    logic [15:0] prod;
    logic [15:0] acc;
    sum  = {1'b0, s} + {1'b0, d};
    prod = {8'd0, d} * {8'd0, sa};
    acc  = {sum[7:0], 8'd0} - prod;
    return acc[15:8];
  endfunction

  assign pop = stat.nempty && (!out_valid_r || !out_stall);

  always_comb begin
    for (int i = 0; i < gcab_pkg::NUM_CH; i++) begin
      src_s[i] = div255_round(head_entry.prod[i]);
    end
    src_a = src_s[gcab_pkg::CH_A];
  end

  always_comb begin
    pixel_nxt = head_entry.word;
    we_nxt    = 1'b1;
    unique case (head_entry.cls)
      gcab_pkg::CLS_SKIP: begin
        we_nxt = 1'b0;
      end
      gcab_pkg::CLS_FULL: begin
        we_nxt = 1'b1;
      end
      gcab_pkg::CLS_BLEND: begin
        for (int i = 0; i < gcab_pkg::NUM_CH; i++) begin
          pixel_nxt[i*gcab_pkg::CHAN_W +: gcab_pkg::CHAN_W] =
            blend_ch(src_s[i], head_entry.word[i*gcab_pkg::CHAN_W +: gcab_pkg::CHAN_W],
                     src_a);
        end
      end
      default: begin
        we_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pixel_r <= pixel_nxt;
      we_r    <= we_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = pixel_r;
  assign out_write_enable = we_r;

endmodule

@@ hdl/glyph_coverage_alpha_blend_core.sv @@
// channel   direction  ports
// in        input      in_valid, in_stall, in_pixel_x, in_pixel_y, in_coverage, in_dest_pixel
// out       output     out_valid, out_stall, out_pixel_out, out_write_enable
// cfg       input      cfg_write_en, cfg_index, cfg_data
//
// one word in and one word out per clock when neither side stalls
// a word is registered into a queue slot, then goes through the blend into the output register
// throughput is set by the four-entry queue and the single output register
// rst_n is synchronous active low; it empties the queue and the output register
// in_stall rises only when the queue is full; out_stall holds the output word in place
module glyph_coverage_alpha_blend_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [gcab_pkg::COORD_WIDTH-1:0] in_pixel_x,
  input  logic [gcab_pkg::COORD_WIDTH-1:0] in_pixel_y,
  input  logic [gcab_pkg::COV_W-1:0]       in_coverage,
  input  logic [gcab_pkg::PIXEL_W-1:0]     in_dest_pixel,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gcab_pkg::PIXEL_W-1:0]     out_pixel_out,
  output logic                             out_write_enable,
  // configuration port
  input  logic                             cfg_write_en,
  input  logic [gcab_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gcab_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [gcab_pkg::PIXEL_W-1:0]   source_color_r;
  logic [gcab_pkg::PIXEL_W-1:0]   full_word_r;
  logic [gcab_pkg::CLIP_LO_W-1:0] clip_left_r;
  logic [gcab_pkg::CLIP_LO_W-1:0] clip_top_r;
  logic [gcab_pkg::CLIP_HI_W-1:0] clip_right_r;
  logic [gcab_pkg::CLIP_HI_W-1:0] clip_bottom_r;

  gcab_pkg::entry_t front_entry;
  gcab_pkg::entry_t head_entry;
  gcab_pkg::qstat_t qstat;
  logic             push;
  logic             pop;

  // register decode, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_color_r <= '0;
      full_word_r    <= '0;
      clip_left_r    <= '0;
      clip_top_r     <= '0;
      clip_right_r   <= gcab_pkg::CLIP_HI_RESET;
      clip_bottom_r  <= gcab_pkg::CLIP_HI_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        gcab_pkg::REG_SOURCE_COLOR: source_color_r <= cfg_data;
        gcab_pkg::REG_FULL_WORD:    full_word_r    <= cfg_data;
        gcab_pkg::REG_CLIP_LEFT:    clip_left_r    <= cfg_data[gcab_pkg::CLIP_LO_W-1:0];
        gcab_pkg::REG_CLIP_TOP:     clip_top_r     <= cfg_data[gcab_pkg::CLIP_LO_W-1:0];
        gcab_pkg::REG_CLIP_RIGHT:   clip_right_r   <= cfg_data[gcab_pkg::CLIP_HI_W-1:0];
        gcab_pkg::REG_CLIP_BOTTOM:  clip_bottom_r  <= cfg_data[gcab_pkg::CLIP_HI_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: clip test, coverage class and the source-times-coverage products
  gcab_front u_front (
    .pixel_x      (in_pixel_x),
    .pixel_y      (in_pixel_y),
    .coverage     (in_coverage),
    .dest_pixel   (in_dest_pixel),
    .source_color (source_color_r),
    .full_word    (full_word_r),
    .clip_left    (clip_left_r),
    .clip_top     (clip_top_r),
    .clip_right   (clip_right_r),
    .clip_bottom  (clip_bottom_r),
    .entry        (front_entry)
  );

  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  // queue decouples the two halves; its slots register the products
  gcab_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (front_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .stat       (qstat)
  );

  // back: rounding divide, source-over blend and the output register
  gcab_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_entry       (head_entry),
    .stat             (qstat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_out    (out_pixel_out),
    .out_write_enable (out_write_enable)
  );

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && qstat.nempty) |=> out_valid)
    else $error("back end idled with a queued word");
`endif

endmodule
